[hw/rtl/euler_to_rotation_matrix_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Euler angle to rotation matrix block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ERTM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ertm: check failed");

// next-cycle implication
`define ERTM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ertm: check failed");

`else

`define ERTM_ASSERT_IMP(label, clk, rst, ante, cons)
`define ERTM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/ertm_pkg.sv]
// ----------------------------------------------------------------------------
// ertm_pkg
// Types, constants and arithmetic helpers for the rotation matrix block.
// ----------------------------------------------------------------------------
package ertm_pkg;

  // angle and fixed-point format
  localparam int ANGLE_BITS    = 16;
  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;

  localparam int FIELD_W    = 16;
  localparam int TURN_W     = 32;
  localparam int TURN_SHIFT = TURN_W - ANGLE_BITS;
  localparam int Q_W        = 32;              // Q2.30 datapath
  localparam int Z_W        = TURN_W + 1;      // residual angle
  localparam int SUM_W      = Q_W + 1;
  localparam int PROD_W     = 2 * Q_W;
  localparam int OUT_SHIFT  = 30 - FRAC_BITS;
  localparam int STAGE_W    = 5;               // index into the atan table
  localparam int NUM_AXES   = 3;

  localparam int AX_YAW   = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_ROLL  = 2;

  localparam logic signed [Q_W-1:0]    KGAIN    = 32'sd652032874;
  localparam logic signed [PROD_W-1:0] Q30_HALF = 64'sd536870912;
  localparam logic signed [SUM_W-1:0]  OUT_HALF =
    (OUT_SHIFT == 0) ? '0 : SUM_W'(64'd1 << (OUT_SHIFT - 1));
  localparam logic signed [SUM_W-1:0]  OUT_LIM  = SUM_W'(64'd1 << FRAC_BITS);
  localparam logic signed [FIELD_W-1:0] OUT_LIM_FIELD = FIELD_W'(64'd1 << FRAC_BITS);

  // atan(2^-i) in 2^32-per-turn units
  localparam logic [TURN_W-1:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BF, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // one rotator lane
  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic                  flip;
  } lane_t;

  typedef lane_t [NUM_AXES-1:0] axes_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m00;
    logic signed [FIELD_W-1:0] m01;
    logic signed [FIELD_W-1:0] m02;
    logic signed [FIELD_W-1:0] m10;
    logic signed [FIELD_W-1:0] m11;
    logic signed [FIELD_W-1:0] m12;
    logic signed [FIELD_W-1:0] m20;
    logic signed [FIELD_W-1:0] m21;
    logic signed [FIELD_W-1:0] m22;
  } mat_t;

  // Q30 x Q30 -> Q30, round half up
  function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                 input logic signed [Q_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b) + Q30_HALF;
    return p[30 +: Q_W];
  endfunction

  // Q30 sum -> output format, round half up and clamp to +/-1.0
  function automatic logic signed [FIELD_W-1:0] finish(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + OUT_HALF) >>> OUT_SHIFT;
    if (r > OUT_LIM) begin
      r = OUT_LIM;
    end else if (r < -OUT_LIM) begin
      r = -OUT_LIM;
    end
    return r[FIELD_W-1:0];
  endfunction

endpackage

[hw/rtl/ertm_if.sv]
// ----------------------------------------------------------------------------
// ertm_angles_if / ertm_matrix_if
// Valid/ready channels for angle triples and matrix results.
// ----------------------------------------------------------------------------
interface ertm_angles_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ertm_pkg::FIELD_W-1:0] yaw_angle;
  logic signed [ertm_pkg::FIELD_W-1:0] pitch_angle;
  logic signed [ertm_pkg::FIELD_W-1:0] roll_angle;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface ertm_matrix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ertm_pkg::FIELD_W-1:0] m00;
  logic signed [ertm_pkg::FIELD_W-1:0] m01;
  logic signed [ertm_pkg::FIELD_W-1:0] m02;
  logic signed [ertm_pkg::FIELD_W-1:0] m10;
  logic signed [ertm_pkg::FIELD_W-1:0] m11;
  logic signed [ertm_pkg::FIELD_W-1:0] m12;
  logic signed [ertm_pkg::FIELD_W-1:0] m20;
  logic signed [ertm_pkg::FIELD_W-1:0] m21;
  logic signed [ertm_pkg::FIELD_W-1:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

[hw/rtl/ertm_cordic_cell.sv]
// ----------------------------------------------------------------------------
// ertm_cordic_cell
// One registered CORDIC rotation step for all three axes, with its own
// valid bit; hands the rotated lanes to the next cell.
// ----------------------------------------------------------------------------
module ertm_cordic_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ertm_pkg::STAGE_W-1:0]     stage,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  ertm_pkg::axes_t                  up_data,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output ertm_pkg::axes_t                  dn_data
);

  ertm_pkg::axes_t                    rot;
  logic signed [ertm_pkg::Z_W-1:0]    step;

  assign step     = ertm_pkg::Z_W'(ertm_pkg::ATAN_TURNS[stage]);
  assign up_ready = !dn_valid || dn_ready;

  // micro-rotation toward zero residual angle, per axis
  always_comb begin
    for (int a = 0; a < ertm_pkg::NUM_AXES; a++) begin
      rot[a].flip = up_data[a].flip;
      if (!up_data[a].z[ertm_pkg::Z_W-1]) begin
        rot[a].x = up_data[a].x - (up_data[a].y >>> stage);
        rot[a].y = up_data[a].y + (up_data[a].x >>> stage);
        rot[a].z = up_data[a].z - step;
      end else begin
        rot[a].x = up_data[a].x + (up_data[a].y >>> stage);
        rot[a].y = up_data[a].y - (up_data[a].x >>> stage);
        rot[a].z = up_data[a].z + step;
      end
    end
  end

  // beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data <= rot;
    end
  end

endmodule

[hw/rtl/ertm_matrix_unit.sv]
// ----------------------------------------------------------------------------
// ertm_matrix_unit
// Quadrant fix-up, pairwise and triple products, sums and output rounding,
// five registered steps with an elastic valid/ready chain.
// ----------------------------------------------------------------------------
module ertm_matrix_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  ertm_pkg::axes_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output ertm_pkg::mat_t   dn_data
);

  localparam int QW = ertm_pkg::Q_W;
  localparam int SW = ertm_pkg::SUM_W;

  // step valids and readies
  logic va, vb, vc, vd;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  // step A: cos/sin per axis
  logic signed [QW-1:0] cs_c [ertm_pkg::NUM_AXES];
  logic signed [QW-1:0] cs_s [ertm_pkg::NUM_AXES];

  // step B: pairwise products
  logic signed [QW-1:0] b_s1s2, b_c1s2, b_c1c3, b_s1c3, b_c1s3, b_s1s3;
  logic signed [QW-1:0] b_c2s3, b_c2c3, b_s1c2, b_c1c2, b_s2, b_s3, b_c3;

  // step C: triple products plus pass-through
  logic signed [QW-1:0] c_s1s2s3, c_s1s2c3, c_c1s2s3, c_c1s2c3;
  logic signed [QW-1:0] c_c1c3, c_s1c3, c_c1s3, c_s1s3;
  logic signed [QW-1:0] c_c2s3, c_c2c3, c_s1c2, c_c1c2, c_s2;

  // step D: element sums
  logic signed [SW-1:0] d_m00, d_m01, d_m02, d_m10, d_m11, d_m12;
  logic signed [SW-1:0] d_m20, d_m21, d_m22;

  assign rdy_e    = !dn_valid || dn_ready;
  assign rdy_d    = !vd || rdy_e;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign up_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      vd       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= up_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
      if (rdy_e) dn_valid <= vd;
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      for (int a = 0; a < ertm_pkg::NUM_AXES; a++) begin
        cs_c[a] <= up_data[a].flip ? -up_data[a].x : up_data[a].x;
        cs_s[a] <= up_data[a].flip ? -up_data[a].y : up_data[a].y;
      end
    end
  end

  // pairwise products
  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_s1s2 <= ertm_pkg::qmul(cs_s[ertm_pkg::AX_YAW], cs_s[ertm_pkg::AX_PITCH]);
      b_c1s2 <= ertm_pkg::qmul(cs_c[ertm_pkg::AX_YAW], cs_s[ertm_pkg::AX_PITCH]);
      b_c1c3 <= ertm_pkg::qmul(cs_c[ertm_pkg::AX_YAW], cs_c[ertm_pkg::AX_ROLL]);
      b_s1c3 <= ertm_pkg::qmul(cs_s[ertm_pkg::AX_YAW], cs_c[ertm_pkg::AX_ROLL]);
      b_c1s3 <= ertm_pkg::qmul(cs_c[ertm_pkg::AX_YAW], cs_s[ertm_pkg::AX_ROLL]);
      b_s1s3 <= ertm_pkg::qmul(cs_s[ertm_pkg::AX_YAW], cs_s[ertm_pkg::AX_ROLL]);
      b_c2s3 <= ertm_pkg::qmul(cs_c[ertm_pkg::AX_PITCH], cs_s[ertm_pkg::AX_ROLL]);
      b_c2c3 <= ertm_pkg::qmul(cs_c[ertm_pkg::AX_PITCH], cs_c[ertm_pkg::AX_ROLL]);
      b_s1c2 <= ertm_pkg::qmul(cs_s[ertm_pkg::AX_YAW], cs_c[ertm_pkg::AX_PITCH]);
      b_c1c2 <= ertm_pkg::qmul(cs_c[ertm_pkg::AX_YAW], cs_c[ertm_pkg::AX_PITCH]);
      b_s2   <= cs_s[ertm_pkg::AX_PITCH];
      b_s3   <= cs_s[ertm_pkg::AX_ROLL];
      b_c3   <= cs_c[ertm_pkg::AX_ROLL];
    end
  end

  // triple products, rounded after each multiply
  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_s1s2s3 <= ertm_pkg::qmul(b_s1s2, b_s3);
      c_s1s2c3 <= ertm_pkg::qmul(b_s1s2, b_c3);
      c_c1s2s3 <= ertm_pkg::qmul(b_c1s2, b_s3);
      c_c1s2c3 <= ertm_pkg::qmul(b_c1s2, b_c3);
      c_c1c3   <= b_c1c3;
      c_s1c3   <= b_s1c3;
      c_c1s3   <= b_c1s3;
      c_s1s3   <= b_s1s3;
      c_c2s3   <= b_c2s3;
      c_c2c3   <= b_c2c3;
      c_s1c2   <= b_s1c2;
      c_c1c2   <= b_c1c2;
      c_s2     <= b_s2;
    end
  end

  // element sums, exact in Q30
  always_ff @(posedge clk) begin
    if (rdy_d) begin
      d_m00 <= SW'(c_c1c3) - SW'(c_s1s2s3);
      d_m01 <= -SW'(c_c2s3);
      d_m02 <= -SW'(c_s1c3) - SW'(c_c1s2s3);
      d_m10 <= SW'(c_c1s3) + SW'(c_s1s2c3);
      d_m11 <= SW'(c_c2c3);
      d_m12 <= SW'(c_c1s2c3) - SW'(c_s1s3);
      d_m20 <= SW'(c_s1c2);
      d_m21 <= -SW'(c_s2);
      d_m22 <= SW'(c_c1c2);
    end
  end

  // output register: round and clamp
  always_ff @(posedge clk) begin
    if (rdy_e) begin
      dn_data.m00 <= ertm_pkg::finish(d_m00);
      dn_data.m01 <= ertm_pkg::finish(d_m01);
      dn_data.m02 <= ertm_pkg::finish(d_m02);
      dn_data.m10 <= ertm_pkg::finish(d_m10);
      dn_data.m11 <= ertm_pkg::finish(d_m11);
      dn_data.m12 <= ertm_pkg::finish(d_m12);
      dn_data.m20 <= ertm_pkg::finish(d_m20);
      dn_data.m21 <= ertm_pkg::finish(d_m21);
      dn_data.m22 <= ertm_pkg::finish(d_m22);
    end
  end

endmodule

[hw/rtl/euler_to_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Yaw/pitch/roll angles in, 3x3 rotation matrix in Q1.14 out.
// ----------------------------------------------------------------------------
// Usage:
//   angles: one beat carries yaw, pitch and roll in binary angle units
//   (65536 per turn). Set roll to zero for the yaw-pitch form.
//   matrix: one beat per input beat, elements m00..m22, row-major, Q1.14.
// Throughput: one beat per cycle while matrix.ready is high. An accepted
//   angle beat is registered in each cell of the CORDIC chain, then at
//   quadrant fix-up, pairwise products, triple products, sums and the
//   rounding output register, which presents its matrix beat.
// Every register step has its own valid bit, so bubbles close up and the
//   input stays ready while a finished matrix waits at the output.
// Stall: a low matrix.ready holds the output beat; beats back up through
//   the chain and angles.ready drops only once every step is full.
// Reset: rst clears all valid bits; nothing else is stored between beats.
// ----------------------------------------------------------------------------
`include "euler_to_rotation_matrix_assert.svh"

module euler_to_rotation_matrix (
  input  logic          clk,
  input  logic          rst,
  ertm_angles_if.sink   angles,
  ertm_matrix_if.source matrix
);

  localparam int N = ertm_pkg::CORDIC_STAGES;

  logic              valid_c [N+1];
  logic              ready_c [N+1];
  ertm_pkg::axes_t   data_c  [N+1];
  ertm_pkg::mat_t    mat;
  logic              m11_in_range;

  logic signed [ertm_pkg::FIELD_W-1:0] ang [ertm_pkg::NUM_AXES];

  assign ang[ertm_pkg::AX_YAW]   = angles.yaw_angle;
  assign ang[ertm_pkg::AX_PITCH] = angles.pitch_angle;
  assign ang[ertm_pkg::AX_ROLL]  = angles.roll_angle;

  // turn fraction, fold into [-90, 90) deg, start vector
  always_comb begin
    logic [ertm_pkg::TURN_W-1:0] u;
    logic                        fl;
    for (int a = 0; a < ertm_pkg::NUM_AXES; a++) begin
      u  = ertm_pkg::TURN_W'(ang[a]) << ertm_pkg::TURN_SHIFT;
      fl = u[ertm_pkg::TURN_W-1] ^ u[ertm_pkg::TURN_W-2];
      u[ertm_pkg::TURN_W-1] = u[ertm_pkg::TURN_W-1] ^ fl;
      data_c[0][a].x    = ertm_pkg::KGAIN;
      data_c[0][a].y    = '0;
      data_c[0][a].z    = ertm_pkg::Z_W'(signed'(u));
      data_c[0][a].flip = fl;
    end
  end

  assign valid_c[0]   = angles.valid;
  assign angles.ready = ready_c[0];

  // CORDIC chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    ertm_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .stage    (ertm_pkg::STAGE_W'(g)),
      .up_valid (valid_c[g]),
      .up_ready (ready_c[g]),
      .up_data  (data_c[g]),
      .dn_valid (valid_c[g+1]),
      .dn_ready (ready_c[g+1]),
      .dn_data  (data_c[g+1])
    );
  end

  ertm_matrix_unit u_matrix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid_c[N]),
    .up_ready (ready_c[N]),
    .up_data  (data_c[N]),
    .dn_valid (matrix.valid),
    .dn_ready (matrix.ready),
    .dn_data  (mat)
  );

  assign matrix.m00 = mat.m00;
  assign matrix.m01 = mat.m01;
  assign matrix.m02 = mat.m02;
  assign matrix.m10 = mat.m10;
  assign matrix.m11 = mat.m11;
  assign matrix.m12 = mat.m12;
  assign matrix.m20 = mat.m20;
  assign matrix.m21 = mat.m21;
  assign matrix.m22 = mat.m22;

  // m11 stays within +/-1.0 unless only the low bits are kept
  assign m11_in_range = (ertm_pkg::FRAC_BITS > 14) ||
                        ($signed(matrix.m11) <= ertm_pkg::OUT_LIM_FIELD &&
                         $signed(matrix.m11) >= -ertm_pkg::OUT_LIM_FIELD);

  // checks
  `ERTM_ASSERT_IMP(a_ready_when_first_empty, clk, rst, !valid_c[1], angles.ready)
  `ERTM_ASSERT_NXT(a_accept_fills_first, clk, rst, angles.valid && angles.ready, valid_c[1])
  `ERTM_ASSERT_IMP(a_m11_clamped, clk, rst, matrix.valid, m11_in_range)

endmodule
